[rtl/mrpn_pkg.sv]
// Package for the MIDI RPN/NRPN event decoder: event and message codes,
// controller numbers and channel table sizes. No dependencies.
`timescale 1ns / 1ps

package mrpn_pkg;

	localparam int CHANNELS   = 16;
	localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int CMD_W      = 4;
	localparam int CHAN_W     = 8;
	localparam int NUM_W      = 14;
	localparam int AMT_W      = 15;
	localparam int TYPE_W     = 4;
	localparam int FIELDS_W   = CMD_W + CHAN_W + NUM_W + AMT_W;
	localparam int TDATA_W    = ((FIELDS_W + 7) / 8) * 8;

	localparam logic [NUM_W-1:0] NULL_PARAM  = 14'd16383;
	localparam logic [NUM_W-1:0] CC_DATA_MSB = 14'd6;
	localparam logic [NUM_W-1:0] CC_DATA_LSB = 14'd38;
	localparam logic [NUM_W-1:0] CC_NRPN_LSB = 14'd98;
	localparam logic [NUM_W-1:0] CC_NRPN_MSB = 14'd99;
	localparam logic [NUM_W-1:0] CC_RPN_LSB  = 14'd100;
	localparam logic [NUM_W-1:0] CC_RPN_MSB  = 14'd101;

	typedef enum logic [CMD_W-1:0] {
		CMD_CONTROLLER = 4'd0,
		CMD_NRPN       = 4'd1,
		CMD_RPN        = 4'd2,
		CMD_PROGRAM    = 4'd3,
		CMD_NOTE_ON    = 4'd4,
		CMD_NOTE_OFF   = 4'd5,
		CMD_KEY_PRESS  = 4'd6,
		CMD_CHAN_PRESS = 4'd7,
		CMD_BEND       = 4'd8,
		CMD_OTHER      = 4'd9
	} cmd_t;

	typedef enum logic [TYPE_W-1:0] {
		MSG_NOTEOFF    = 4'd0,
		MSG_NOTEON     = 4'd1,
		MSG_AFTERTOUCH = 4'd2,
		MSG_CONTROL    = 4'd3,
		MSG_PROGRAM    = 4'd4,
		MSG_PRESSURE   = 4'd5,
		MSG_BEND       = 4'd6,
		MSG_RPN        = 4'd7,
		MSG_NRPN       = 4'd8,
		MSG_UNKNOWN    = 4'd9
	} msg_type_t;

endpackage

[rtl/midi_rpn_nrpn_event_decoder_core.sv]
// MIDI RPN/NRPN event decoder: input register, decode and per-channel
// parameter table, result register. Depends on mrpn_pkg.
`timescale 1ns / 1ps

// The block takes one decoded MIDI event per item and returns at most one typed
// message. It accepts one item per clock cycle unless a message waits in the
// stalled result register; the rate is set by the per-channel parameter table,
// which is read and rewritten as an item leaves the input register for the
// result register. Controllers 6, 98..101 on channels below 16, and controller
// 38 while the parameter index is 16383, only update the table and give no
// message. The table clears to zero (NRPN mode) on reset.
module midi_rpn_nrpn_event_decoder_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// cmd[3:0], chan[11:4], number[25:12], amount[40:26], zero fill above
	input  logic [mrpn_pkg::TDATA_W-1:0]    s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// msg_type[3:0], msg_channel[11:4], msg_number[25:12], msg_value[40:26], zero fill
	output logic [mrpn_pkg::TDATA_W-1:0]    m_axis_tdata
);
	import mrpn_pkg::*;

	// input register
	logic                    valid_s1;
	cmd_t                    cmd_s1;
	logic [CHAN_W-1:0]       chan_s1;
	logic [NUM_W-1:0]        number_s1;
	logic [AMT_W-1:0]        amount_s1;

	// result register
	logic                    valid_s2;
	msg_type_t               type_s2;
	logic [CHAN_W-1:0]       chan_s2;
	logic [NUM_W-1:0]        number_s2;
	logic [AMT_W-1:0]        value_s2;

	// per-channel table
	logic                    mode_q  [CHANNELS];
	logic [NUM_W-1:0]        index_q [CHANNELS];
	logic [NUM_W-1:0]        data_q  [CHANNELS];

	logic                    s2_free;
	logic                    leave_s1;
	logic                    emit;
	msg_type_t               type_d;
	logic [CHAN_W-1:0]       chan_d;
	logic [NUM_W-1:0]        number_d;
	logic [AMT_W-1:0]        value_d;
	logic [CH_IDX_W-1:0]     idx;
	logic                    bypass;
	logic [6:0]              v7;
	logic                    mode_cur;
	logic [NUM_W-1:0]        index_cur;
	logic [NUM_W-1:0]        data_cur;
	logic                    mode_nxt;
	logic [NUM_W-1:0]        index_nxt;
	logic [NUM_W-1:0]        data_nxt;

	assign idx       = chan_s1[CH_IDX_W-1:0];
	assign bypass    = (chan_s1 >= CHAN_W'(CHANNELS));
	assign v7        = amount_s1[6:0];
	assign mode_cur  = mode_q[idx];
	assign index_cur = index_q[idx];
	assign data_cur  = data_q[idx];

	always_comb begin
		emit      = 1'b1;
		type_d    = MSG_CONTROL;
		chan_d    = chan_s1;
		number_d  = number_s1;
		value_d   = amount_s1;
		mode_nxt  = mode_cur;
		index_nxt = index_cur;
		data_nxt  = data_cur;
		unique case (cmd_s1)
			CMD_CONTROLLER: begin
				type_d = MSG_CONTROL;
				if (!bypass) begin
					case (number_s1) inside
						CC_DATA_MSB: begin
							data_nxt = {v7, 7'b0};
							emit     = 1'b0;
						end
						CC_DATA_LSB: begin
							data_nxt = data_cur | {7'b0, v7};
							emit     = (index_cur != NULL_PARAM);
							type_d   = mode_cur ? MSG_RPN : MSG_NRPN;
							number_d = index_cur;
							value_d  = {1'b0, data_cur | {7'b0, v7}};
						end
						CC_NRPN_LSB, CC_RPN_LSB: begin
							mode_nxt  = (number_s1 == CC_RPN_LSB);
							index_nxt = index_cur | {7'b0, v7};
							emit      = 1'b0;
						end
						CC_NRPN_MSB, CC_RPN_MSB: begin
							mode_nxt  = (number_s1 == CC_RPN_MSB);
							index_nxt = {v7, 7'b0};
							emit      = 1'b0;
						end
						default: ;
					endcase
				end
			end
			CMD_NRPN:       type_d = MSG_NRPN;
			CMD_RPN:        type_d = MSG_RPN;
			CMD_PROGRAM: begin
				type_d   = MSG_PROGRAM;
				number_d = '0;
			end
			CMD_NOTE_ON:    type_d = MSG_NOTEON;
			CMD_NOTE_OFF:   type_d = MSG_NOTEOFF;
			CMD_KEY_PRESS:  type_d = MSG_AFTERTOUCH;
			CMD_CHAN_PRESS: begin
				type_d   = MSG_PRESSURE;
				number_d = '0;
			end
			CMD_BEND: begin
				type_d   = MSG_BEND;
				number_d = '0;
			end
			default: begin
				type_d   = MSG_UNKNOWN;
				chan_d   = '0;
				number_d = '0;
				value_d  = '0;
			end
		endcase
	end

	// an item with no message leaves even while the result register is stalled
	assign s2_free       = !valid_s2 || m_axis_tready;
	assign leave_s1      = valid_s1 && (s2_free || !emit);
	assign s_axis_tready = !valid_s1 || leave_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1    <= cmd_t'(s_axis_tdata[3:0]);
			chan_s1   <= s_axis_tdata[11:4];
			number_s1 <= s_axis_tdata[25:12];
			amount_s1 <= s_axis_tdata[40:26];
		end
	end

	// read-modify-write of the addressed channel as the item leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				mode_q[i]  <= 1'b0;
				index_q[i] <= '0;
				data_q[i]  <= '0;
			end
		end else if (leave_s1) begin
			mode_q[idx]  <= mode_nxt;
			index_q[idx] <= index_nxt;
			data_q[idx]  <= data_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= leave_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && leave_s1 && emit) begin
			type_s2   <= type_d;
			chan_s2   <= chan_d;
			number_s2 <= number_d;
			value_s2  <= value_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {(TDATA_W - FIELDS_W)'(0), value_s2, number_s2, chan_s2, type_s2};

`ifndef SYNTHESIS
	a_direct_emits: assert property (@(posedge clk) disable iff (!arst_n)
		leave_s1 && (cmd_s1 != CMD_CONTROLLER) |=> valid_s2)
		else $error("non-controller item produced no message");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (type_s2 == MSG_UNKNOWN) |->
			(chan_s2 == '0) && (number_s2 == '0) && (value_s2 == '0))
		else $error("unknown message carries non-zero fields");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s_axis_tready |-> valid_s2 && !m_axis_tready)
		else $error("input stalled without a stalled result");
`endif

endmodule
